// ===== design/cbcc_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the chunked body checker.
package cbcc_pkg;

  localparam int DEFAULT_COUNT_BITS = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    VERDICT_INCOMPLETE = 2'd0,
    VERDICT_COMPLETE   = 2'd1,
    VERDICT_MALFORMED  = 2'd2
  } verdict_t;

  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_DATA    = 6'b000010,
    PH_END1    = 6'b000100,
    PH_END2    = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_body;
  } in_item_t;

  typedef struct packed {
    verdict_t verdict;
  } out_item_t;

  // Input register contents handed to the parser.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] ch);
    hex_t       r;
    logic [7:0] diff;
    r = '0;
    diff = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      diff = ch - 8'h30;
      r.is_hex = 1'b1;
      r.value = diff[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      diff = ch - 8'h37;
      r.is_hex = 1'b1;
      r.value = diff[3:0];
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      diff = ch - 8'h57;
      r.is_hex = 1'b1;
      r.value = diff[3:0];
    end
    return r;
  endfunction

endpackage

// ===== design/cbcc_if.sv =====
// Valid/ready channel interfaces for the input bytes and the verdicts.
interface cbcc_in_if;
  logic               valid;
  logic               ready;
  cbcc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbcc_out_if;
  logic                valid;
  logic                ready;
  cbcc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/cbcc_in_stage.sv =====
// Input register stage: holds one accepted byte until the parser takes it.
module cbcc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbcc_pkg::in_item_t in_item,
  input  logic               take,
  output cbcc_pkg::stage_t   stage
);

  assign in_ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.item <= in_item;
    end
  end

endmodule

// ===== design/cbcc_parser.sv =====
// Framing state update for one byte and the verdict result register.
module cbcc_parser #(
  parameter int COUNT_BITS = cbcc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  cbcc_pkg::stage_t    stage,
  output logic                take,
  output logic                out_valid,
  output cbcc_pkg::out_item_t out_item,
  input  logic                out_ready
);

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  digit_seen;
    logic                  size_fault;
    logic                  in_extension;
  } size_st_t;

  // One character of a size line; everything after ';' is ignored.
  function automatic size_st_t size_char(input size_st_t s, input logic [7:0] ch);
    size_st_t       r;
    cbcc_pkg::hex_t h;
    r = s;
    h = cbcc_pkg::hex_decode(ch);
    if (!s.in_extension) begin
      if (ch == cbcc_pkg::CH_SEMI) begin
        r.in_extension = 1'b1;
      end else if (!h.is_hex) begin
        r.size_fault = 1'b1;
      end else begin
        r.digit_seen = 1'b1;
        if (s.count[COUNT_BITS-1 -: 4] != 4'd0) begin
          r.size_fault = 1'b1;
        end else begin
          r.count = {s.count[COUNT_BITS-5:0], h.value};
        end
      end
    end
    return r;
  endfunction

  cbcc_pkg::phase_t      phase, phase_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic                  digit_seen, digit_seen_next;
  logic                  size_fault, size_fault_next;
  logic                  in_extension, in_extension_next;
  logic                  cr_pending, cr_pending_next;
  logic                  line_empty, line_empty_next;
  cbcc_pkg::verdict_t    held_verdict, held_verdict_next;

  assign take = stage.valid && (!out_valid || out_ready);

  always_comb begin
    size_st_t              s;
    logic [7:0]            ch;
    logic [COUNT_BITS-1:0] cnt_dec;
    ch = stage.item.data_byte;

    // A new body starts from the reset state.
    if (stage.item.start_of_body) begin
      phase_next        = cbcc_pkg::PH_SIZE;
      byte_count_next   = '0;
      digit_seen_next   = 1'b0;
      size_fault_next   = 1'b0;
      in_extension_next = 1'b0;
      cr_pending_next   = 1'b0;
      line_empty_next   = 1'b1;
      held_verdict_next = cbcc_pkg::VERDICT_INCOMPLETE;
    end else begin
      phase_next        = phase;
      byte_count_next   = byte_count;
      digit_seen_next   = digit_seen;
      size_fault_next   = size_fault;
      in_extension_next = in_extension;
      cr_pending_next   = cr_pending;
      line_empty_next   = line_empty;
      held_verdict_next = held_verdict;
    end

    s = '{count: byte_count_next, digit_seen: digit_seen_next,
          size_fault: size_fault_next, in_extension: in_extension_next};
    cnt_dec = byte_count_next - {{(COUNT_BITS-1){1'b0}}, 1'b1};

    case (phase_next)
      cbcc_pkg::PH_SIZE: begin
        if (cr_pending_next && ch == cbcc_pkg::CH_LF) begin
          cr_pending_next = 1'b0;
          if (s.size_fault || !s.digit_seen) begin
            held_verdict_next = cbcc_pkg::VERDICT_MALFORMED;
            phase_next = cbcc_pkg::PH_DONE;
          end else if (s.count == '0) begin
            phase_next = cbcc_pkg::PH_TRAILER;
            line_empty_next = 1'b1;
          end else begin
            phase_next = cbcc_pkg::PH_DATA;
          end
        end else begin
          // A lone CR counts as an ordinary size line character.
          if (cr_pending_next) begin
            s = size_char(s, cbcc_pkg::CH_CR);
          end
          if (ch == cbcc_pkg::CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            cr_pending_next = 1'b0;
            s = size_char(s, ch);
          end
          byte_count_next   = s.count;
          digit_seen_next   = s.digit_seen;
          size_fault_next   = s.size_fault;
          in_extension_next = s.in_extension;
        end
      end
      cbcc_pkg::PH_DATA: begin
        byte_count_next = cnt_dec;
        if (cnt_dec == '0) begin
          phase_next = cbcc_pkg::PH_END1;
        end
      end
      cbcc_pkg::PH_END1: begin
        cr_pending_next = (ch == cbcc_pkg::CH_CR);
        phase_next = cbcc_pkg::PH_END2;
      end
      cbcc_pkg::PH_END2: begin
        if (cr_pending_next && ch == cbcc_pkg::CH_LF) begin
          phase_next        = cbcc_pkg::PH_SIZE;
          byte_count_next   = '0;
          digit_seen_next   = 1'b0;
          size_fault_next   = 1'b0;
          in_extension_next = 1'b0;
          cr_pending_next   = 1'b0;
        end else begin
          held_verdict_next = cbcc_pkg::VERDICT_MALFORMED;
          phase_next = cbcc_pkg::PH_DONE;
        end
      end
      cbcc_pkg::PH_TRAILER: begin
        if (cr_pending_next && ch == cbcc_pkg::CH_LF) begin
          cr_pending_next = 1'b0;
          if (line_empty_next) begin
            held_verdict_next = cbcc_pkg::VERDICT_COMPLETE;
            phase_next = cbcc_pkg::PH_DONE;
          end else begin
            line_empty_next = 1'b1;
          end
        end else begin
          if (cr_pending_next) begin
            line_empty_next = 1'b0;
          end
          if (ch == cbcc_pkg::CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            cr_pending_next = 1'b0;
            line_empty_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cbcc_pkg::PH_SIZE;
      byte_count   <= '0;
      digit_seen   <= 1'b0;
      size_fault   <= 1'b0;
      in_extension <= 1'b0;
      cr_pending   <= 1'b0;
      line_empty   <= 1'b1;
      held_verdict <= cbcc_pkg::VERDICT_INCOMPLETE;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        digit_seen   <= digit_seen_next;
        size_fault   <= size_fault_next;
        in_extension <= in_extension_next;
        cr_pending   <= cr_pending_next;
        line_empty   <= line_empty_next;
        held_verdict <= held_verdict_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.verdict <= held_verdict_next;
    end
  end

endmodule

// ===== design/chunked_body_completion_check.sv =====
// Chunked transfer coding framing checker: one body byte in, one verdict out.
//
// in_ch carries one body byte per transfer together with start_of_body, which
// clears all framing state so that this byte opens a new body. out_ch returns
// one verdict per input byte, in order: incomplete, complete or malformed for
// the body seen so far. Complete and malformed hold until the next
// start_of_body.
//
// An input transfer reaches its verdict on out_ch through the input register
// and then, via the framing update, the result register. Throughput is one
// byte per cycle while out_ch is not stalled.
//
// Reset (rst, synchronous) empties both registers and puts the framing state
// at the start of a size line with an incomplete verdict. When the receiver
// stalls, the verdict holds in the result register, one more byte waits in
// the input register, and in_ch.ready then drops until out_ch moves again.
module chunked_body_completion_check #(
  parameter int COUNT_BITS = cbcc_pkg::DEFAULT_COUNT_BITS
) (
  input logic        clk,
  input logic        rst,
  cbcc_in_if.sink    in_ch,
  cbcc_out_if.source out_ch
);

  cbcc_pkg::stage_t stage;
  logic             take;

  cbcc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_ch.payload),
    .take     (take),
    .stage    (stage)
  );

  cbcc_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .take      (take),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.payload),
    .out_ready (out_ch.ready)
  );

endmodule

// ===== design/cbcc_checker.sv =====
// Port-level checks for the chunked body checker, bound to the top level.
module cbcc_checker (
  input logic        clk,
  input logic        rst,
  cbcc_in_if.sink    in_ch,
  cbcc_out_if.source out_ch
);

  // Hold a stalled verdict.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("stalled verdict changed or dropped");

  // A verdict appearing on an empty output comes from a byte accepted through the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
    else $error("verdict without a matching byte transfer");

  // With nothing waiting at the output, the input side never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output is empty");

  // Reset leaves no verdict behind.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_ch.valid)
    else $error("verdict present right after reset");

endmodule

bind chunked_body_completion_check cbcc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ===== test/tb_chunked_body_completion_check.sv =====
// Testbench for the chunked body completion checker: chunked bodies in, per-byte verdicts checked.
`timescale 1ns / 100ps

module tb_chunked_body_completion_check;
  import cbcc_pkg::*;

  localparam int COUNT_BITS    = DEFAULT_COUNT_BITS;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 970;

  typedef enum {BODY_GOOD, BODY_BROKEN, BODY_ODD, BODY_NOISE} body_kind_t;
  typedef enum {MUT_CORRUPT, MUT_TRUNCATE, MUT_INSERT, MUT_DROP} mutation_t;
  typedef enum {
    ODD_OVERFLOW, ODD_MAX_SIZE, ODD_NO_DIGIT, ODD_BAD_DIGIT,
    ODD_LONE_CR_SIZE, ODD_BAD_DATA_END, ODD_LONE_CR_TRAILER
  } oddity_t;

  typedef struct {
    phase_t      phase;
    logic [63:0] count;
    bit          digit_seen;
    bit          size_fault;
    bit          in_ext;
    bit          cr_pending;
    bit          line_empty;
    verdict_t    verdict;
  } framing_t;

  logic clk = 1'b0;
  logic rst;

  cbcc_in_if  in_ch ();
  cbcc_out_if out_ch ();

  chunked_body_completion_check #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  framing_t   frame;
  verdict_t   verdicts_due[$];
  logic [7:0] body_bytes[$];
  int         mismatches    = 0;
  int         counted_items = 0;
  int         idle_cycles   = 0;
  bit         tx_gaps       = 1'b0;
  bit         rx_stalls     = 1'b0;
  bit         hold_off_req  = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- framing predictor

  function automatic void open_size_line();
    frame.phase      = PH_SIZE;
    frame.count      = '0;
    frame.digit_seen = 1'b0;
    frame.size_fault = 1'b0;
    frame.in_ext     = 1'b0;
    frame.cr_pending = 1'b0;
  endfunction

  function automatic void clear_framing();
    open_size_line();
    frame.line_empty = 1'b1;
    frame.verdict    = VERDICT_INCOMPLETE;
  endfunction

  function automatic int hex_digit(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    return -1;
  endfunction

  function automatic void take_size_char(input logic [7:0] ch);
    int d;
    d = hex_digit(ch);
    if (frame.in_ext) return;
    if (ch == CH_SEMI) begin
      frame.in_ext = 1'b1;
      return;
    end
    if (d < 0) begin
      frame.size_fault = 1'b1;
      return;
    end
    frame.digit_seen = 1'b1;
    // a digit that would push the size past the counter width is a fault
    if ((frame.count >> (COUNT_BITS - 4)) != 0) begin
      frame.size_fault = 1'b1;
      return;
    end
    frame.count = (frame.count << 4) | 64'(d);
  endfunction

  function automatic verdict_t step_framing(input logic [7:0] ch, input logic sob);
    bit line_done;
    line_done = 1'b0;
    if (sob) clear_framing();
    case (frame.phase)
      PH_SIZE: begin
        if (frame.cr_pending) begin
          frame.cr_pending = 1'b0;
          if (ch == CH_LF) line_done = 1'b1;
          else take_size_char(CH_CR);
        end
        if (line_done) begin
          if (frame.size_fault || !frame.digit_seen) begin
            frame.verdict = VERDICT_MALFORMED;
            frame.phase   = PH_DONE;
          end else if (frame.count == 0) begin
            frame.phase      = PH_TRAILER;
            frame.line_empty = 1'b1;
          end else begin
            frame.phase = PH_DATA;
          end
        end else if (ch == CH_CR) begin
          frame.cr_pending = 1'b1;
        end else begin
          take_size_char(ch);
        end
      end
      PH_DATA: begin
        frame.count = frame.count - 1;
        if (frame.count == 0) frame.phase = PH_END1;
      end
      PH_END1: begin
        frame.cr_pending = (ch == CH_CR);
        frame.phase      = PH_END2;
      end
      PH_END2: begin
        if (frame.cr_pending && ch == CH_LF) begin
          open_size_line();
        end else begin
          frame.verdict = VERDICT_MALFORMED;
          frame.phase   = PH_DONE;
        end
      end
      PH_TRAILER: begin
        if (frame.cr_pending) begin
          frame.cr_pending = 1'b0;
          if (ch == CH_LF) begin
            line_done = 1'b1;
            if (frame.line_empty) begin
              frame.verdict = VERDICT_COMPLETE;
              frame.phase   = PH_DONE;
            end else begin
              frame.line_empty = 1'b1;
            end
          end else begin
            frame.line_empty = 1'b0;
          end
        end
        if (!line_done) begin
          if (ch == CH_CR) frame.cr_pending = 1'b1;
          else frame.line_empty = 1'b0;
        end
      end
      default: ;
    endcase
    return frame.verdict;
  endfunction

  // ---------------------------------------------------------------- body builders

  function automatic void add_byte(input logic [7:0] b);
    body_bytes = {body_bytes, b};
  endfunction

  function automatic void push_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void push_hex(input logic [63:0] v);
    int         n;
    int         i;
    logic [3:0] nib;
    n = 1;
    while (n < 16 && (v >> (4 * n)) != 0) n++;
    for (i = n - 1; i >= 0; i--) begin
      nib = v[4 * i +: 4];
      if (nib < 10) add_byte(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1) == 1) add_byte(8'h41 + 8'(nib) - 8'd10);
      else add_byte(8'h61 + 8'(nib) - 8'd10);
    end
  endfunction

  // random bytes, never forming a CR LF pair inside the text
  function automatic void push_rand_text(input int n);
    logic [7:0] b;
    int         i;
    for (i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (body_bytes.size() != 0 && body_bytes[$] == CH_CR && b == CH_LF) b = "x";
      add_byte(b);
    end
  endfunction

  function automatic void push_size_line(input logic [63:0] v);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) add_byte("0");
    push_hex(v);
    if ($urandom_range(0, 3) == 0) begin
      add_byte(CH_SEMI);
      push_rand_text($urandom_range(0, 6));
    end
    push_crlf();
  endfunction

  function automatic void build_wellformed();
    int size;
    int r;
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 70) size = $urandom_range(1, 8);
      else if (r < 95) size = $urandom_range(9, 40);
      else size = $urandom_range(41, 120);
      push_size_line(64'(size));
      repeat (size) add_byte(8'($urandom));
      push_crlf();
    end
    push_size_line('0);
    repeat ($urandom_range(0, 2)) begin
      push_rand_text($urandom_range(1, 8));
      push_crlf();
    end
    push_crlf();
    // trailing bytes past the verdict
    if ($urandom_range(0, 3) == 0) push_rand_text($urandom_range(1, 3));
  endfunction

  function automatic void build_broken();
    int        pos;
    mutation_t m;
    build_wellformed();
    pos = $urandom_range(0, body_bytes.size() - 1);
    m = mutation_t'($urandom_range(0, 3));
    case (m)
      MUT_CORRUPT:  body_bytes[pos] = 8'($urandom);
      MUT_TRUNCATE: while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
      MUT_INSERT:   body_bytes.insert(pos, 8'($urandom));
      MUT_DROP:     if (body_bytes.size() > 1) body_bytes.delete(pos);
      default: ;
    endcase
  endfunction

  function automatic void build_oddity();
    oddity_t    k;
    logic [7:0] b;
    int         size;
    k = oddity_t'($urandom_range(0, 6));
    case (k)
      ODD_OVERFLOW: begin
        push_hex({16'h0, 16'($urandom_range(1, 65535)), 32'($urandom)});
        push_crlf();
      end
      ODD_MAX_SIZE: begin
        // largest size the counter holds: valid, body stays incomplete
        push_hex(64'hFFFF_FFFF);
        push_crlf();
        push_rand_text($urandom_range(1, 5));
      end
      ODD_NO_DIGIT: begin
        if ($urandom_range(0, 1) == 1) begin
          add_byte(CH_SEMI);
          push_rand_text($urandom_range(0, 4));
        end
        push_crlf();
      end
      ODD_BAD_DIGIT: begin
        push_hex(64'($urandom_range(1, 255)));
        do b = 8'($urandom); while (hex_digit(b) >= 0 || b == CH_CR || b == CH_SEMI);
        add_byte(b);
        push_crlf();
      end
      ODD_LONE_CR_SIZE: begin
        push_hex(64'($urandom_range(1, 15)));
        add_byte(CH_CR);
        do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
        add_byte(b);
        push_crlf();
      end
      ODD_BAD_DATA_END: begin
        size = $urandom_range(1, 4);
        push_size_line(64'(size));
        repeat (size) add_byte(8'($urandom));
        case ($urandom_range(0, 2))
          0: begin
            add_byte(CH_CR);
            do b = 8'($urandom); while (b == CH_LF);
            add_byte(b);
          end
          1: begin
            do b = 8'($urandom); while (b == CH_CR);
            add_byte(b);
            add_byte(CH_LF);
          end
          default: begin
            add_byte(CH_LF);
            add_byte(CH_CR);
          end
        endcase
      end
      default: begin
        push_size_line('0);
        push_rand_text($urandom_range(0, 3));
        add_byte(CH_CR);
        do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
        add_byte(b);
        push_crlf();
        push_crlf();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic sob);
    int       gap;
    verdict_t due;
    gap = tx_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid                 = 1'b1;
    in_ch.payload.data_byte     = b;
    in_ch.payload.start_of_body = sob;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    counted_items++;
    due = step_framing(b, sob);
    verdicts_due = {verdicts_due, due};
  endtask

  task automatic send_body(input bit fresh);
    int i;
    for (i = 0; i < body_bytes.size(); i++) send_byte(body_bytes[i], fresh && i == 0);
    body_bytes.delete();
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (verdicts_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: verdict %0d with none expected", $realtime, out_ch.payload.verdict);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.payload.verdict !== want) begin
          if (mismatches < 10)
            $display("%0t: verdict expected %0d, got %0d", $realtime, want,
                     out_ch.payload.verdict);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    // shortest complete body, then a byte after the verdict
    add_byte("0");
    push_crlf();
    push_crlf();
    add_byte(8'hFF);
    send_body(1'b1);
    // extreme data bytes, then a bad end after the data
    add_byte("2");
    push_crlf();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte("X");
    send_body(1'b1);
    // size line with no digit before the extension
    add_byte(CH_SEMI);
    push_crlf();
    send_body(1'b1);
    // lone CR inside the size digits
    add_byte("1");
    add_byte(CH_CR);
    add_byte("x");
    push_crlf();
    send_body(1'b1);
    // one past the largest size
    push_hex(64'h1_0000_0000);
    push_crlf();
    send_body(1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_backpressure();
    tx_gaps      = 1'b0;
    rx_stalls    = 1'b0;
    hold_off_req = 1'b1;
    push_size_line(64'd24);
    repeat (24) add_byte(8'($urandom));
    push_crlf();
    push_size_line('0);
    push_crlf();
    send_body(1'b1);
    wait_for_verdicts();
  endtask

  task automatic test_random_bodies();
    int         target;
    int         r;
    body_kind_t k;
    bit         fresh;
    target = counted_items + RANDOM_ITEMS;
    while (counted_items < target) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_gaps   = 1'($urandom_range(0, 1));
        rx_stalls = 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 60) k = BODY_GOOD;
      else if (r < 80) k = BODY_BROKEN;
      else if (r < 92) k = BODY_ODD;
      else k = BODY_NOISE;
      fresh = 1'b1;
      case (k)
        BODY_GOOD:   build_wellformed();
        BODY_BROKEN: build_broken();
        BODY_ODD:    build_oddity();
        default: begin
          push_rand_text($urandom_range(1, 12));
          fresh = ($urandom_range(0, 3) != 0);
        end
      endcase
      send_body(fresh);
    end
    wait_for_verdicts();
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    clear_framing();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_bodies();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
